// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// shared types, widths and codes of the complex arithmetic unit
// ----------------------------------------------------------------------------
`default_nettype none

package cau_pkg;

    localparam int WORD_WIDTH = 16;
    localparam int FRAC_BITS  = 8;

    // product and sum magnitudes
    localparam int MAG_W = 2 * WORD_WIDTH;
    // quotient carries one extra fraction bit for rounding
    localparam int QUO_W = WORD_WIDTH + 1;
    // divider partial remainder
    localparam int REM_W = 3 * WORD_WIDTH + FRAC_BITS + 1;

    localparam int FQ_DEPTH = 4;
    localparam int FQ_AW    = $clog2(FQ_DEPTH);
    localparam int OQ_DEPTH = 32;
    localparam int OQ_AW    = $clog2(OQ_DEPTH);

    localparam logic [1:0] CMD_ADD = 2'd0;
    localparam logic [1:0] CMD_MUL = 2'd1;
    localparam logic [1:0] CMD_DIV = 2'd2;
    localparam logic [1:0] CMD_MOD = 2'd3;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_DIV_ZERO = 2'd1;
    localparam logic [1:0] ST_SAT      = 2'd2;

    typedef logic signed [WORD_WIDTH-1:0] word_t;

    typedef struct packed {
        logic [1:0] command;
        word_t      a_re;
        word_t      a_im;
        word_t      b_re;
        word_t      b_im;
    } in_item_t;

    typedef struct packed {
        word_t      res_re;
        word_t      res_im;
        logic [1:0] status;
    } out_item_t;

    // classified operation handed from front to back
    typedef struct packed {
        in_item_t item;
        logic     b_zero;
    } op_t;

    // back to result queue
    typedef struct packed {
        logic issue;
        logic valid;
    } res_ctrl_t;

    // clamp a sign-magnitude value to the word range, flag in the top bit
    function automatic logic [WORD_WIDTH:0] saturate(input logic neg,
                                                     input logic [MAG_W-1:0] mag);
        logic [MAG_W-1:0]      maxp;
        logic [MAG_W-1:0]      maxn;
        logic [WORD_WIDTH-1:0] w;
        logic                  f;
        maxp = {{(MAG_W-WORD_WIDTH+1){1'b0}}, {(WORD_WIDTH-1){1'b1}}};
        maxn = {{(MAG_W-WORD_WIDTH){1'b0}}, 1'b1, {(WORD_WIDTH-1){1'b0}}};
        if (!neg) begin
            f = (mag > maxp);
            w = f ? maxp[WORD_WIDTH-1:0] : mag[WORD_WIDTH-1:0];
        end
        else begin
            f = (mag > maxn);
            w = f ? maxn[WORD_WIDTH-1:0] : (~mag[WORD_WIDTH-1:0] + 1'b1);
        end
        return {f, w};
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/cau_front.sv =====
// ----------------------------------------------------------------------------
// cau_front
// accepts operand sets, classifies them and queues them for the back end
// ----------------------------------------------------------------------------
`default_nettype none

module cau_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    output logic                  full,
    input  wire cau_pkg::in_item_t operands,
    input  wire logic             take,
    output logic                  avail,
    output cau_pkg::op_t          op
);

    cau_pkg::op_t                 mem [cau_pkg::FQ_DEPTH];
    logic [cau_pkg::FQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cau_pkg::FQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cau_pkg::FQ_AW:0]      count_reg, count_next;
    logic                         do_wr, do_rd;
    cau_pkg::op_t                 cls;

    assign full  = (count_reg == (cau_pkg::FQ_AW+1)'(cau_pkg::FQ_DEPTH));
    assign avail = (count_reg != '0);
    assign do_wr = push && !full;
    assign do_rd = take && avail;
    assign op    = mem[rd_ptr_reg];

    // divide by zero is known from the operands alone
    always_comb
    begin
        cls.item   = operands;
        cls.b_zero = (operands.b_re == '0) && (operands.b_im == '0);
    end

    always_comb
    begin
        wr_ptr_next = do_wr ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (cau_pkg::FQ_AW+1)'(do_wr)
                                - (cau_pkg::FQ_AW+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem[wr_ptr_reg] <= cls;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cau_back.sv =====
// ----------------------------------------------------------------------------
// cau_back
// pipelined datapath: products, sums, rounding, divider and square root
// ----------------------------------------------------------------------------
`default_nettype none

module cau_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              avail,
    input  wire cau_pkg::op_t      op,
    input  wire logic              space,
    output logic                   take,
    output cau_pkg::res_ctrl_t     ctrl,
    output cau_pkg::out_item_t     res
);

    localparam int W  = cau_pkg::WORD_WIDTH;
    localparam int F  = cau_pkg::FRAC_BITS;
    localparam int MW = cau_pkg::MAG_W;
    localparam int QW = cau_pkg::QUO_W;
    localparam int RW = cau_pkg::REM_W;

    typedef struct packed {
        logic             valid;
        logic [1:0]       command;
        logic             b_zero;
        logic signed [MW-1:0] p0;
        logic signed [MW-1:0] p1;
        logic signed [MW-1:0] p2;
        logic signed [MW-1:0] p3;
        logic signed [MW-1:0] p4;
        logic signed [MW-1:0] p5;
        logic signed [W:0]    sum_re;
        logic signed [W:0]    sum_im;
    } s1_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       command;
        logic             b_zero;
        logic             re_neg;
        logic [MW-1:0]    re_mag;
        logic             im_neg;
        logic [MW-1:0]    im_mag;
        logic [MW-1:0]    den;
        logic [W-1:0]     pre_re;
        logic [W-1:0]     pre_im;
        logic [1:0]       pre_st;
    } s2_t;

    typedef struct packed {
        logic             valid;
        logic [1:0]       command;
        logic             b_zero;
        logic [W-1:0]     pre_re;
        logic [W-1:0]     pre_im;
        logic [1:0]       pre_st;
        logic             re_neg;
        logic             im_neg;
        logic             ovf_re;
        logic             ovf_im;
        logic [RW-1:0]    rem_re;
        logic [RW-1:0]    rem_im;
        logic [QW-1:0]    q_re;
        logic [QW-1:0]    q_im;
        logic [MW-1:0]    den;
        logic [MW-1:0]    sq_rem;
        logic [W-1:0]     sq_root;
    } ds_t;

    s1_t  s1_reg, s1_next;
    s2_t  s2_reg, s2_next;
    ds_t  ds_reg [QW+1];
    ds_t  ds_next [QW+1];
    cau_pkg::out_item_t out_reg, out_next;
    logic out_valid_reg;

    assign take       = avail && space;
    assign ctrl.issue = take;
    assign ctrl.valid = out_valid_reg;
    assign res        = out_reg;

    // stage 1: six multipliers, squares of A replace those of B for modulus
    always_comb
    begin
        cau_pkg::in_item_t it;
        logic signed [W-1:0] sq_x, sq_y;
        it = op.item;
        sq_x = (it.command == cau_pkg::CMD_MOD) ? it.a_re : it.b_re;
        sq_y = (it.command == cau_pkg::CMD_MOD) ? it.a_im : it.b_im;
        s1_next.valid   = take;
        s1_next.command = it.command;
        s1_next.b_zero  = op.b_zero;
        s1_next.p0      = MW'($signed(it.a_re) * $signed(it.b_re));
        s1_next.p1      = MW'($signed(it.a_im) * $signed(it.b_im));
        s1_next.p2      = MW'($signed(it.a_im) * $signed(it.b_re));
        s1_next.p3      = MW'($signed(it.a_re) * $signed(it.b_im));
        s1_next.p4      = MW'(sq_x * sq_x);
        s1_next.p5      = MW'(sq_y * sq_y);
        s1_next.sum_re  = (W+1)'($signed(it.a_re)) + (W+1)'($signed(it.b_re));
        s1_next.sum_im  = (W+1)'($signed(it.a_im)) + (W+1)'($signed(it.b_im));
    end

    // stage 2: cross sums, denominator, add result
    always_comb
    begin
        logic signed [MW+1:0] e0, e1, e2, e3, xr, xi;
        logic [W:0]           sat_r, sat_i;
        logic                 is_div;
        e0 = {{2{s1_reg.p0[MW-1]}}, s1_reg.p0};
        e1 = {{2{s1_reg.p1[MW-1]}}, s1_reg.p1};
        e2 = {{2{s1_reg.p2[MW-1]}}, s1_reg.p2};
        e3 = {{2{s1_reg.p3[MW-1]}}, s1_reg.p3};
        is_div = (s1_reg.command == cau_pkg::CMD_DIV);
        // multiply uses A*B, divide uses A*conj(B)
        xr = is_div ? e0 + e1 : e0 - e1;
        xi = is_div ? e2 - e3 : e2 + e3;
        s2_next.valid   = s1_reg.valid;
        s2_next.command = s1_reg.command;
        s2_next.b_zero  = s1_reg.b_zero;
        s2_next.re_neg  = xr[MW+1];
        s2_next.re_mag  = xr[MW+1] ? MW'(-xr) : MW'(xr);
        s2_next.im_neg  = xi[MW+1];
        s2_next.im_mag  = xi[MW+1] ? MW'(-xi) : MW'(xi);
        s2_next.den     = MW'(s1_reg.p4) + MW'(s1_reg.p5);
        sat_r = cau_pkg::saturate(s1_reg.sum_re[W],
                    s1_reg.sum_re[W] ? MW'(-(MW+1)'(s1_reg.sum_re))
                                     : MW'((MW+1)'(s1_reg.sum_re)));
        sat_i = cau_pkg::saturate(s1_reg.sum_im[W],
                    s1_reg.sum_im[W] ? MW'(-(MW+1)'(s1_reg.sum_im))
                                     : MW'((MW+1)'(s1_reg.sum_im)));
        s2_next.pre_re  = sat_r[W-1:0];
        s2_next.pre_im  = sat_i[W-1:0];
        s2_next.pre_st  = (sat_r[W] || sat_i[W]) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
    end

    // stage 3: rounding for multiply, divider and root setup
    always_comb
    begin
        logic [MW-1:0] rnd_r, rnd_i;
        logic [W:0]    sat_r, sat_i;
        logic [RW-1:0] den_top;
        rnd_r = (s2_reg.re_mag >> F) + MW'(s2_reg.re_mag[F-1]);
        rnd_i = (s2_reg.im_mag >> F) + MW'(s2_reg.im_mag[F-1]);
        sat_r = cau_pkg::saturate(s2_reg.re_neg, rnd_r);
        sat_i = cau_pkg::saturate(s2_reg.im_neg, rnd_i);
        den_top = RW'(s2_reg.den) << W;

        ds_next[0].valid   = s2_reg.valid;
        ds_next[0].command = s2_reg.command;
        ds_next[0].b_zero  = s2_reg.b_zero;
        ds_next[0].re_neg  = s2_reg.re_neg;
        ds_next[0].im_neg  = s2_reg.im_neg;
        // quotient would not fit the extended word
        ds_next[0].ovf_re  = (RW'(s2_reg.re_mag) << F) >= den_top;
        ds_next[0].ovf_im  = (RW'(s2_reg.im_mag) << F) >= den_top;
        ds_next[0].rem_re  = RW'(s2_reg.re_mag) << (F + 1);
        ds_next[0].rem_im  = RW'(s2_reg.im_mag) << (F + 1);
        ds_next[0].q_re    = '0;
        ds_next[0].q_im    = '0;
        ds_next[0].den     = s2_reg.den;
        ds_next[0].sq_rem  = s2_reg.den;
        ds_next[0].sq_root = '0;
        case (s2_reg.command)
            cau_pkg::CMD_ADD:
            begin
                ds_next[0].pre_re = s2_reg.pre_re;
                ds_next[0].pre_im = s2_reg.pre_im;
                ds_next[0].pre_st = s2_reg.pre_st;
            end
            cau_pkg::CMD_MUL:
            begin
                ds_next[0].pre_re = sat_r[W-1:0];
                ds_next[0].pre_im = sat_i[W-1:0];
                ds_next[0].pre_st = (sat_r[W] || sat_i[W]) ? cau_pkg::ST_SAT
                                                           : cau_pkg::ST_OK;
            end
            default:
            begin
                ds_next[0].pre_re = '0;
                ds_next[0].pre_im = '0;
                ds_next[0].pre_st = cau_pkg::ST_DIV_ZERO;
            end
        endcase
    end

    // one quotient bit per stage, and one root bit per stage after the first
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        localparam int J = W - k;
        always_comb
        begin
            logic [RW-1:0] dsh;
            logic [MW:0]   test;
            logic          ge_r, ge_i, ge_s;
            ds_next[k+1] = ds_reg[k];
            dsh  = RW'(ds_reg[k].den) << J;
            ge_r = ds_reg[k].rem_re >= dsh;
            ge_i = ds_reg[k].rem_im >= dsh;
            if (ge_r)
            begin
                ds_next[k+1].rem_re = ds_reg[k].rem_re - dsh;
            end
            if (ge_i)
            begin
                ds_next[k+1].rem_im = ds_reg[k].rem_im - dsh;
            end
            ds_next[k+1].q_re = ds_reg[k].q_re | (QW'(ge_r) << J);
            ds_next[k+1].q_im = ds_reg[k].q_im | (QW'(ge_i) << J);
            test = '0;
            ge_s = 1'b0;
            if (J < W)
            begin
                test = ((MW+1)'(ds_reg[k].sq_root) << (J + 1))
                     + ((MW+1)'(1) << (2 * J));
                ge_s = {1'b0, ds_reg[k].sq_rem} >= test;
                if (ge_s)
                begin
                    ds_next[k+1].sq_rem  = ds_reg[k].sq_rem - MW'(test);
                    ds_next[k+1].sq_root = ds_reg[k].sq_root | (W'(1) << J);
                end
            end
        end
    end

    // final rounding and saturation of divide and modulus; add and multiply results pass through
    always_comb
    begin
        ds_t           d;
        logic [MW-1:0] qr, qi, rt;
        logic [W:0]    sat_r, sat_i, sat_s;
        logic          fr, fi;
        d  = ds_reg[QW];
        qr = MW'((MW)'(d.q_re) + MW'(1)) >> 1;
        qi = MW'((MW)'(d.q_im) + MW'(1)) >> 1;
        rt = MW'(d.sq_root) + MW'(MW'(d.sq_rem) > MW'(d.sq_root));
        sat_r = cau_pkg::saturate(d.re_neg, qr);
        sat_i = cau_pkg::saturate(d.im_neg, qi);
        sat_s = cau_pkg::saturate(1'b0, rt);
        if (d.ovf_re)
        begin
            sat_r = cau_pkg::saturate(d.re_neg, {MW{1'b1}});
        end
        if (d.ovf_im)
        begin
            sat_i = cau_pkg::saturate(d.im_neg, {MW{1'b1}});
        end
        fr = sat_r[W];
        fi = sat_i[W];
        case (d.command)
            cau_pkg::CMD_DIV:
            begin
                if (d.b_zero)
                begin
                    out_next.res_re = '0;
                    out_next.res_im = '0;
                    out_next.status = cau_pkg::ST_DIV_ZERO;
                end
                else
                begin
                    out_next.res_re = sat_r[W-1:0];
                    out_next.res_im = sat_i[W-1:0];
                    out_next.status = (fr || fi) ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
                end
            end
            cau_pkg::CMD_MOD:
            begin
                out_next.res_re = sat_s[W-1:0];
                out_next.res_im = '0;
                out_next.status = sat_s[W] ? cau_pkg::ST_SAT : cau_pkg::ST_OK;
            end
            default:
            begin
                out_next.res_re = d.pre_re;
                out_next.res_im = d.pre_im;
                out_next.status = d.pre_st;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg        <= '0;
            s2_reg        <= '0;
            for (int i = 0; i <= QW; i++)
            begin
                ds_reg[i] <= '0;
            end
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            for (int i = 0; i <= QW; i++)
            begin
                ds_reg[i] <= ds_next[i];
            end
            out_valid_reg <= ds_reg[QW].valid;
            out_reg       <= out_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/cau_outq.sv =====
// ----------------------------------------------------------------------------
// cau_outq
// result queue with slot reservation for items still in the pipeline
// ----------------------------------------------------------------------------
`default_nettype none

module cau_outq (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire cau_pkg::res_ctrl_t ctrl,
    input  wire cau_pkg::out_item_t wr_item,
    output logic                   space,
    input  wire logic              pop,
    output logic                   empty,
    output cau_pkg::out_item_t     result
);

    cau_pkg::out_item_t           mem [cau_pkg::OQ_DEPTH];
    logic [cau_pkg::OQ_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [cau_pkg::OQ_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [cau_pkg::OQ_AW:0]      count_reg, count_next;
    logic [cau_pkg::OQ_AW:0]      resv_reg, resv_next;
    logic                         do_rd;

    assign empty  = (count_reg == '0);
    assign do_rd  = pop && !empty;
    assign result = mem[rd_ptr_reg];
    // slots held by stored results plus items in flight
    assign space  = (resv_reg != (cau_pkg::OQ_AW+1)'(cau_pkg::OQ_DEPTH));

    always_comb
    begin
        wr_ptr_next = ctrl.valid ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_rd ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (cau_pkg::OQ_AW+1)'(ctrl.valid)
                                - (cau_pkg::OQ_AW+1)'(do_rd);
        resv_next   = resv_reg + (cau_pkg::OQ_AW+1)'(ctrl.issue)
                               - (cau_pkg::OQ_AW+1)'(do_rd);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
            resv_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            resv_reg   <= resv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.valid)
        begin
            mem[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/complex_arithmetic_unit_top.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_top
// fixed-point complex ALU: add, multiply, divide and modulus in signed Q8.8
// ----------------------------------------------------------------------------
// Takes one operand set per cycle while the input queue is not full and
// returns one result per operand set, in order, on the result ports. All
// four commands share one 21-register pipeline (multiply, cross sums,
// rounding, a 17-step restoring divider with a 16-step square root running
// alongside, final rounding), so throughput is one transfer per cycle for
// any command mix while a result slot can be reserved. The pipeline never
// stalls: an item is only let in when a slot of the 32-entry result queue
// is reserved for it, so the sustained rate holds as long as results are
// popped at that rate; a 4-entry input queue absorbs short gaps.
`default_nettype none

module complex_arithmetic_unit_top (
    input  wire logic             clk,
    input  wire logic             rst_n,
    // operand side
    input  wire logic             push,
    output logic                  full,
    input  wire cau_pkg::in_item_t operands,
    // result side
    input  wire logic             pop,
    output logic                  empty,
    output cau_pkg::out_item_t    result
);

    // front to back
    logic                 avail;
    logic                 take;
    cau_pkg::op_t         op;

    // back to result queue
    logic                 space;
    cau_pkg::res_ctrl_t   ctrl;
    cau_pkg::out_item_t   res;

    // accept and classify, short queue
    cau_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .full     (full),
        .operands (operands),
        .take     (take),
        .avail    (avail),
        .op       (op)
    );

    // arithmetic pipeline, issues only with a reserved result slot
    cau_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .avail (avail),
        .op    (op),
        .space (space),
        .take  (take),
        .ctrl  (ctrl),
        .res   (res)
    );

    // result queue, each pop frees one reservation
    cau_outq u_outq (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .wr_item (res),
        .space   (space),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

`default_nettype wire
